// ----- rtl/satl_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and reciprocal table of the shelf atlas allocator
package satl_pkg;

	// rounding unit operand widths
	localparam int RND_W       = 17;
	localparam int RECIP_W     = 23;
	localparam int RECIP_SHIFT = 22;

	// register fallbacks
	localparam logic [14:0] DEF_SIZE  = 15'd2048;
	localparam logic [14:0] SIZE_CAP  = 15'd16384;
	localparam logic [3:0]  DEF_LIMIT = 4'd4;
	localparam logic [7:0]  DEF_GAP   = 8'd2;

	// register indexes
	localparam logic [2:0] REG_PAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_PAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_PAGE_LIMIT   = 3'd2;
	localparam logic [2:0] REG_GAP          = 3'd3;
	localparam logic [2:0] REG_BLOCK_WIDTH  = 3'd4;
	localparam logic [2:0] REG_BLOCK_HEIGHT = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_ARG  = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;

	// which value the rounding unit works on, and where the result lands
	typedef enum logic [1:0] {
		RND_AW  = 2'd0,
		RND_AH  = 2'd1,
		RND_PAD = 2'd2,
		RND_ROW = 2'd3
	} rnd_sel_t;

	// effective configuration, fallbacks already applied
	typedef struct packed {
		logic [14:0] pw;
		logic [14:0] ph;
		logic [3:0]  lim;
		logic [7:0]  gap;
		logic [4:0]  bw;
		logic [4:0]  bh;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     rnd_go;
		rnd_sel_t rnd_sel;
		logic     scan_first;
		logic     scan_next;
		logic     clear;
		logic     place;
		logic     open_new;
		logic     fail_arg;
		logic     fail_space;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_clear;
		logic bad_arg;
		logic too_big;
		logic no_pages;
		logic fit;
		logic last_page;
		logic can_open;
	} sts_t;

	// ceil(2^22 / u); floor(v / u) == (v * recip(u)) >> 22 for v < 2^17, u < 32
	function automatic logic [RECIP_W-1:0] recip(input logic [4:0] u);
		logic [RECIP_W-1:0] r;
		unique case (u)
			5'd1:    r = 23'd4194304;
			5'd2:    r = 23'd2097152;
			5'd3:    r = 23'd1398102;
			5'd4:    r = 23'd1048576;
			5'd5:    r = 23'd838861;
			5'd6:    r = 23'd699051;
			5'd7:    r = 23'd599187;
			5'd8:    r = 23'd524288;
			5'd9:    r = 23'd466034;
			5'd10:   r = 23'd419431;
			5'd11:   r = 23'd381301;
			5'd12:   r = 23'd349526;
			5'd13:   r = 23'd322639;
			5'd14:   r = 23'd299594;
			5'd15:   r = 23'd279621;
			5'd16:   r = 23'd262144;
			5'd17:   r = 23'd246724;
			5'd18:   r = 23'd233017;
			5'd19:   r = 23'd220753;
			5'd20:   r = 23'd209716;
			5'd21:   r = 23'd199729;
			5'd22:   r = 23'd190651;
			5'd23:   r = 23'd182362;
			5'd24:   r = 23'd174763;
			5'd25:   r = 23'd167773;
			5'd26:   r = 23'd161320;
			5'd27:   r = 23'd155345;
			5'd28:   r = 23'd149797;
			5'd29:   r = 23'd144632;
			5'd30:   r = 23'd139811;
			5'd31:   r = 23'd135301;
			default: r = 23'd4194304;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/satl_cfg.sv -----
`timescale 1ns / 1ps
// configuration registers and their effective values
module satl_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [2:0]       wr_index,
	input  logic [14:0]      wr_data,
	output satl_pkg::cfg_t   eff
);
	import satl_pkg::*;

	logic [14:0] pw_q;
	logic [14:0] ph_q;
	logic [3:0]  lim_q;
	logic [7:0]  gap_q;
	logic [4:0]  bw_q;
	logic [4:0]  bh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q  <= DEF_SIZE;
			ph_q  <= DEF_SIZE;
			lim_q <= DEF_LIMIT;
			gap_q <= DEF_GAP;
			bw_q  <= 5'd1;
			bh_q  <= 5'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PAGE_WIDTH:   pw_q  <= wr_data;
				REG_PAGE_HEIGHT:  ph_q  <= wr_data;
				REG_PAGE_LIMIT:   lim_q <= wr_data[3:0];
				REG_GAP:          gap_q <= wr_data[7:0];
				REG_BLOCK_WIDTH:  bw_q  <= wr_data[4:0];
				REG_BLOCK_HEIGHT: bh_q  <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	// zero means default, page sizes saturate at the cap
	always_comb begin
		eff.pw  = (pw_q == 15'd0) ? DEF_SIZE : ((pw_q > SIZE_CAP) ? SIZE_CAP : pw_q);
		eff.ph  = (ph_q == 15'd0) ? DEF_SIZE : ((ph_q > SIZE_CAP) ? SIZE_CAP : ph_q);
		eff.lim = (lim_q == 4'd0) ? DEF_LIMIT : lim_q;
		eff.gap = (gap_q == 8'd0) ? DEF_GAP : gap_q;
		eff.bw  = (bw_q == 5'd0) ? 5'd1 : bw_q;
		eff.bh  = (bh_q == 5'd0) ? 5'd1 : bh_q;
	end

endmodule

// ----- rtl/satl_round.sv -----
`timescale 1ns / 1ps
// two-step round-up-to-multiple unit: reciprocal multiply, then scale back
module satl_round (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  satl_pkg::rnd_sel_t            sel,
	input  logic [satl_pkg::RND_W-1:0]    val,
	input  logic [4:0]                    unit,
	output logic                          res_vld,
	output satl_pkg::rnd_sel_t            res_sel,
	output logic [satl_pkg::RND_W-1:0]    res
);
	import satl_pkg::*;

	localparam int PROD_W = RND_W + RECIP_W;
	localparam int BACK_W = RND_W + 5;

	logic [PROD_W-1:0] prod_s1;
	logic [4:0]        unit_s1;
	rnd_sel_t          sel_s1;
	logic              vld_s1;
	logic [RND_W-1:0]  quot;
	logic [BACK_W-1:0] back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= go;
		end
	end

	// val already carries the +unit-1, so the floor quotient gives the round-up
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(val) * PROD_W'(recip(unit));
		unit_s1 <= unit;
		sel_s1  <= sel;
	end

	assign quot    = prod_s1[RECIP_SHIFT +: RND_W];
	assign back    = BACK_W'(quot) * BACK_W'(unit_s1);
	assign res     = back[RND_W-1:0];
	assign res_vld = vld_s1;
	assign res_sel = sel_s1;

endmodule

// ----- rtl/satl_dpath.sv -----
`timescale 1ns / 1ps
// allocator datapath: request, rounded sizes, page cursor memory, results
module satl_dpath #(
	parameter int PAGE_SLOTS = 8,
	parameter int COORD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  satl_pkg::cmd_t   cmd,
	input  satl_pkg::cfg_t   cfg,
	input  logic             req_mode,
	input  logic [14:0]      req_width,
	input  logic [14:0]      req_height,
	output satl_pkg::sts_t   sts,
	output logic             done,
	output logic [1:0]       status,
	output logic [2:0]       page_num,
	output logic [13:0]      pos_x,
	output logic [13:0]      pos_y
);
	import satl_pkg::*;

	localparam int IDX_W = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
	localparam int CNT_W = $clog2(PAGE_SLOTS + 1);
	localparam int CB    = COORD_BITS;
	localparam int SW    = ((CB > RND_W) ? CB : RND_W) + 2;
	localparam int ENT_W = 3 * CB;

	// request
	logic              mode_q;
	logic [14:0]       rw_q;
	logic [14:0]       rh_q;

	// rounded sizes
	logic [RND_W-1:0]  aw_q;
	logic [RND_W-1:0]  ah_q;
	logic [RND_W-1:0]  pad_q;
	logic [RND_W-1:0]  row_q;

	// page cursors: {col, row, shelf}
	logic [ENT_W-1:0]  mem [PAGE_SLOTS];
	logic [PAGE_SLOTS-1:0] vld_q;
	logic [ENT_W-1:0]  rd_q;
	logic              rd_vld_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [CNT_W-1:0]  open_q;

	logic              we;
	logic [IDX_W-1:0]  wa;
	logic [ENT_W-1:0]  wd;

	logic [CB-1:0]     tx, ty, th;
	logic              wrap;
	logic [SW-1:0]     x_eff, y_eff, h_eff;
	logic [SW-1:0]     shelf_new;

	logic              rnd_vld;
	rnd_sel_t          rnd_dst;
	logic [RND_W-1:0]  rnd_res;
	logic [RND_W-1:0]  rnd_val;
	logic [4:0]        rnd_unit;

	logic              done_q;
	logic [1:0]        status_q;
	logic [2:0]        page_q;
	logic [13:0]       x_q;
	logic [13:0]       y_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req_mode;
			rw_q   <= req_width;
			rh_q   <= req_height;
		end
	end

	// rounding unit operands
	always_comb begin
		unique case (cmd.rnd_sel)
			RND_AW: begin
				rnd_val  = RND_W'(rw_q) + RND_W'(cfg.bw) - RND_W'(1);
				rnd_unit = cfg.bw;
			end
			RND_AH: begin
				rnd_val  = RND_W'(rh_q) + RND_W'(cfg.bh) - RND_W'(1);
				rnd_unit = cfg.bh;
			end
			RND_PAD: begin
				rnd_val  = RND_W'(cfg.gap) + RND_W'(cfg.bw) - RND_W'(1);
				rnd_unit = cfg.bw;
			end
			RND_ROW: begin
				rnd_val  = RND_W'(SW'(ty) + SW'(th) + SW'(pad_q) + SW'(cfg.bh) - SW'(1));
				rnd_unit = cfg.bh;
			end
			default: begin
				rnd_val  = '0;
				rnd_unit = 5'd1;
			end
		endcase
	end

	satl_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (cmd.rnd_go),
		.sel     (cmd.rnd_sel),
		.val     (rnd_val),
		.unit    (rnd_unit),
		.res_vld (rnd_vld),
		.res_sel (rnd_dst),
		.res     (rnd_res)
	);

	always_ff @(posedge clk) begin
		if (rnd_vld) begin
			unique case (rnd_dst)
				RND_AW:  aw_q  <= rnd_res;
				RND_AH:  ah_q  <= rnd_res;
				RND_PAD: pad_q <= rnd_res;
				RND_ROW: row_q <= rnd_res;
				default: ;
			endcase
		end
	end

	// scan pointer and cursor read
	assign rd_addr = cmd.scan_first ? '0 : IDX_W'(idx_q + IDX_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
		end else if (cmd.scan_first || cmd.scan_next) begin
			idx_q    <= rd_addr;
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_first || cmd.scan_next) begin
			rd_q <= mem[rd_addr];
		end
	end

	// a page that was cleared reads as empty
	assign tx = rd_vld_q ? rd_q[3*CB-1:2*CB] : '0;
	assign ty = rd_vld_q ? rd_q[2*CB-1:CB]   : '0;
	assign th = rd_vld_q ? rd_q[CB-1:0]      : '0;

	// an empty row never wraps
	assign wrap  = (tx != '0) &&
		((SW'(tx) + SW'(aw_q) + SW'(pad_q)) > SW'(cfg.pw));
	assign x_eff = wrap ? '0 : SW'(tx);
	assign y_eff = wrap ? SW'(row_q) : SW'(ty);
	assign h_eff = wrap ? '0 : SW'(th);
	assign shelf_new = (h_eff > SW'(ah_q)) ? h_eff : SW'(ah_q);

	// cursor write
	assign we = cmd.place || cmd.open_new;
	assign wa = cmd.place ? idx_q : open_q[IDX_W-1:0];

	always_comb begin
		if (cmd.place) begin
			wd = {CB'(x_eff + SW'(aw_q) + SW'(pad_q)), CB'(y_eff), CB'(shelf_new)};
		end else begin
			wd = {CB'(SW'(aw_q) + SW'(pad_q)), {CB{1'b0}}, CB'(ah_q)};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			open_q <= '0;
		end else begin
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[wa] <= 1'b1;
			end
			if (cmd.open_new) begin
				open_q <= CNT_W'(open_q + CNT_W'(1));
			end
		end
	end

	// status to the controller
	always_comb begin
		sts.is_clear  = mode_q;
		sts.bad_arg   = (rw_q == 15'd0) || (rh_q == 15'd0);
		sts.too_big   = (aw_q > RND_W'(cfg.pw)) || (ah_q > RND_W'(cfg.ph));
		sts.no_pages  = (open_q == '0);
		sts.fit       = (y_eff + SW'(ah_q)) <= SW'(cfg.ph);
		sts.last_page = (int'(idx_q) + 1) >= int'(open_q);
		sts.can_open  = (int'(open_q) < int'(cfg.lim)) && (int'(open_q) < PAGE_SLOTS);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.clear || cmd.fail_arg || cmd.fail_space ||
				cmd.place || cmd.open_new;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.place) begin
			status_q <= ST_OK;
			page_q   <= 3'(idx_q);
			x_q      <= 14'(x_eff);
			y_q      <= 14'(y_eff);
		end else if (cmd.open_new) begin
			status_q <= ST_OK;
			page_q   <= 3'(open_q);
			x_q      <= '0;
			y_q      <= '0;
		end else if (cmd.fail_arg) begin
			status_q <= ST_BAD_ARG;
			page_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
		end else if (cmd.fail_space) begin
			status_q <= ST_NO_SPACE;
			page_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
		end else if (cmd.clear) begin
			status_q <= ST_OK;
			page_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign page_num = page_q;
	assign pos_x    = x_q;
	assign pos_y    = y_q;

endmodule

// ----- rtl/satl_ctrl.sv -----
`timescale 1ns / 1ps
// allocator sequencer: rounding, page scan and result selection
module satl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  satl_pkg::sts_t   sts,
	output satl_pkg::cmd_t   cmd,
	output logic             busy
);
	import satl_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHECK = 9'b000000010,
		S_RND_H = 9'b000000100,
		S_RND_P = 9'b000001000,
		S_SIZE  = 9'b000010000,
		S_WRAP  = 9'b000100000,
		S_WAIT  = 9'b001000000,
		S_FIT   = 9'b010000000,
		S_NEW   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (sts.is_clear) begin
					cmd.clear = 1'b1;
					state_d   = S_IDLE;
				end else if (sts.bad_arg) begin
					cmd.fail_arg = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.rnd_go  = 1'b1;
					cmd.rnd_sel = RND_AW;
					state_d     = S_RND_H;
				end
			end
			S_RND_H: begin
				cmd.rnd_go  = 1'b1;
				cmd.rnd_sel = RND_AH;
				state_d     = S_RND_P;
			end
			S_RND_P: begin
				cmd.rnd_go  = 1'b1;
				cmd.rnd_sel = RND_PAD;
				state_d     = S_SIZE;
			end
			S_SIZE: begin
				priority if (sts.too_big) begin
					cmd.fail_space = 1'b1;
					state_d        = S_IDLE;
				end else if (sts.no_pages) begin
					state_d = S_NEW;
				end else begin
					cmd.scan_first = 1'b1;
					state_d        = S_WRAP;
				end
			end
			S_WRAP: begin
				cmd.rnd_go  = 1'b1;
				cmd.rnd_sel = RND_ROW;
				state_d     = S_WAIT;
			end
			S_WAIT: begin
				state_d = S_FIT;
			end
			S_FIT: begin
				priority if (sts.fit) begin
					cmd.place = 1'b1;
					state_d   = S_IDLE;
				end else if (sts.last_page) begin
					state_d = S_NEW;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_WRAP;
				end
			end
			S_NEW: begin
				if (sts.can_open) begin
					cmd.open_new = 1'b1;
				end else begin
					cmd.fail_space = 1'b1;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ----- rtl/shelf_atlas_allocator.sv -----
`timescale 1ns / 1ps
// top level of the shelf-packing atlas allocator
//
//   channel   signals                                   transfer when
//   --------  ----------------------------------------  ---------------------------
//   request   start, busy, mode, req_width, req_height  start high and busy low
//   result    done, status, page_num, pos_x, pos_y      done high (one cycle)
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid and cfg_ready
//
// a clear or a zero-size request finishes from S_CHECK; otherwise the width,
// height and gap are rounded up from S_CHECK, S_RND_H and S_RND_P, and S_SIZE
// rejects a size larger than the page or starts the page scan. each open page
// is visited in S_WRAP, S_WAIT and S_FIT: registered cursor read, then the
// reciprocal round-up unit for the wrapped row start; when all open pages miss,
// S_NEW opens a new page or refuses.
// arst_n clears the sequencer, page count, cursor valid bits, config registers and done.
// the result is shown for one cycle only; busy drops in that same cycle,
// so a new request can be taken while the previous result is on the ports.
module shelf_atlas_allocator #(
	parameter int PAGE_SLOTS = 8,
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [14:0] req_width,
	input  logic [14:0] req_height,
	// result
	output logic        done,
	output logic [1:0]  status,
	output logic [2:0]  page_num,
	output logic [13:0] pos_x,
	output logic [13:0] pos_y,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	import satl_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// registers can always take a write; change them only between requests (not enforced)
	assign cfg_ready = 1'b1;

	satl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.eff      (cfg)
	);

	// sequencer: decides what the datapath does each cycle
	satl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: rounding, cursor memory, fit tests and the result register
	satl_dpath #(
		.PAGE_SLOTS (PAGE_SLOTS),
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.req_mode   (mode),
		.req_width  (req_width),
		.req_height (req_height),
		.sts        (sts),
		.done       (done),
		.status     (status),
		.page_num   (page_num),
		.pos_x      (pos_x),
		.pos_y      (pos_y)
	);

`ifndef ASSERT_OFF
	// a result only follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// an accepted request always occupies the block the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start work");

	// error results carry zero placement fields
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_BAD_ARG || status == ST_NO_SPACE)) |->
		(page_num == 3'd0 && pos_x == 14'd0 && pos_y == 14'd0))
		else $error("error result with nonzero placement");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_BAD_ARG || status == ST_NO_SPACE))
		else $error("undefined status code");
`endif

endmodule
